[src/assert_macros.svh]
// assertion macros used by the convolution controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C2D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("c2d assertion failed");
`define C2D_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("c2d forbidden condition");
`else
`define C2D_ASSERT(lbl, prop)
`define C2D_NEVER(lbl, expr)
`endif
`endif

[src/c2d_pkg.sv]
// types and constants of the same-size convolution block
`timescale 1ns / 1ps
package c2d_pkg;

  localparam int IDX_W      = 6;
  localparam int DATA_W     = 16;
  localparam int OUT_W      = 40;
  localparam int PROD_W     = 32;
  localparam int POS_W      = 9;
  localparam int DIM_W      = 7;
  localparam int KDIM_W     = 3;
  localparam int FRAC_W     = 4;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [REQ_W-1:0] REQ_LOAD_KERNEL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_IMAGE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS   = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [KDIM_W-1:0] krows;
    logic [KDIM_W-1:0] kcols;
    logic [FRAC_W-1:0] frac;
  } cfg_t;

  typedef struct packed {
    logic              wr_kernel;
    logic              wr_image;
    logic              capture;
    logic              clear;
    logic              tap_go;
    logic              tap_last;
    logic [KDIM_W-1:0] tap_a;
    logic [KDIM_W-1:0] tap_b;
    logic              bypass;
    logic              load_out;
    logic              err;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_image;
    logic acc_done;
  } dp_sts_t;

endpackage

[src/c2d_cfg.sv]
// configuration registers with clamping to the storage limits
`timescale 1ns / 1ps
module c2d_cfg #(
  parameter int MAX_ROWS        = 64,
  parameter int MAX_COLS        = 64,
  parameter int MAX_KERNEL_ROWS = 7,
  parameter int MAX_KERNEL_COLS = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]     cfg_data,
  output c2d_pkg::cfg_t                      cfg
);
  import c2d_pkg::*;

  logic [DIM_W-1:0]  image_rows_r, image_cols_r;
  logic [KDIM_W-1:0] kernel_rows_r, kernel_cols_r;
  logic [FRAC_W-1:0] frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r  <= 7'd64;
      image_cols_r  <= 7'd64;
      kernel_rows_r <= 3'd3;
      kernel_cols_r <= 3'd3;
      frac_r        <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_ROWS:  image_rows_r  <= cfg_data;
        CFG_IMAGE_COLS:  image_cols_r  <= cfg_data;
        CFG_KERNEL_ROWS: kernel_rows_r <= cfg_data[KDIM_W-1:0];
        CFG_KERNEL_COLS: kernel_cols_r <= cfg_data[KDIM_W-1:0];
        CFG_FRAC_BITS:   frac_r        <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rows  = (int'(image_rows_r) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : image_rows_r;
    cfg.cols  = (int'(image_cols_r) > MAX_COLS) ? DIM_W'(MAX_COLS) : image_cols_r;
    cfg.krows = (int'(kernel_rows_r) > MAX_KERNEL_ROWS) ? KDIM_W'(MAX_KERNEL_ROWS)
                                                         : kernel_rows_r;
    cfg.kcols = (int'(kernel_cols_r) > MAX_KERNEL_COLS) ? KDIM_W'(MAX_KERNEL_COLS)
                                                         : kernel_cols_r;
    cfg.frac  = frac_r;
  end

endmodule

[src/c2d_ctrl.sv]
// controller: accepts items and steps the tap sequence of a compute
`timescale 1ns / 1ps
`include "assert_macros.svh"
module c2d_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [c2d_pkg::REQ_W-1:0]       in_req_type,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  c2d_pkg::cfg_t                   cfg,
  input  c2d_pkg::dp_sts_t                sts,
  output c2d_pkg::ctrl_cmd_t              cmd
);
  import c2d_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [KDIM_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic              bypass_r, bypass_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              fire;
  logic              kernel_empty;
  logic              last_tap;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign fire         = in_valid && in_ready;
  assign kernel_empty = (cfg.krows == '0) || (cfg.kcols == '0);
  assign last_tap     = bypass_r ||
                        ((a_r == cfg.krows - 3'd1) && (b_r == cfg.kcols - 3'd1));

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    bypass_nxt    = bypass_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.tap_a     = a_r;
    cmd.tap_b     = b_r;
    cmd.bypass    = bypass_r;
    cmd.err       = err_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          case (in_req_type)
            REQ_LOAD_KERNEL: cmd.wr_kernel = 1'b1;
            REQ_LOAD_IMAGE:  cmd.wr_image = 1'b1;
            REQ_COMPUTE: begin
              cmd.capture = 1'b1;
              if (sts.in_image) begin
                cmd.clear  = 1'b1;
                a_nxt      = '0;
                b_nxt      = '0;
                bypass_nxt = kernel_empty;
                err_nxt    = 1'b0;
                state_nxt  = S_RUN;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_FINISH;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd.tap_go   = 1'b1;
        cmd.tap_last = last_tap;
        if (last_tap) begin
          state_nxt = S_DRAIN;
        end else if (b_r == cfg.kcols - 3'd1) begin
          b_nxt = '0;
          a_nxt = a_r + 3'd1;
        end else begin
          b_nxt = b_r + 3'd1;
        end
      end
      S_DRAIN: begin
        if (sts.acc_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_r         <= '0;
      b_r         <= '0;
      bypass_r    <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      bypass_r    <= bypass_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `C2D_NEVER(a_done_outside_drain, sts.acc_done && (state_r != S_DRAIN))
  `C2D_ASSERT(a_out_from_finish, $rose(out_valid_r) |-> $past(state_r == S_FINISH))
  `C2D_ASSERT(a_run_in_kernel, (state_r == S_RUN) && !bypass_r |->
              (a_r < cfg.krows) && (b_r < cfg.kcols))

endmodule

[src/c2d_dp.sv]
// datapath: stores, tap addressing, multiply-accumulate and result register
`timescale 1ns / 1ps
module c2d_dp #(
  parameter int MAX_ROWS        = 64,
  parameter int MAX_COLS        = 64,
  parameter int MAX_KERNEL_ROWS = 7,
  parameter int MAX_KERNEL_COLS = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [c2d_pkg::IDX_W-1:0]           in_row_index,
  input  logic [c2d_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [c2d_pkg::DATA_W-1:0]   in_data_value,
  input  c2d_pkg::cfg_t                       cfg,
  input  c2d_pkg::ctrl_cmd_t                  cmd,
  output c2d_pkg::dp_sts_t                    sts,
  output logic signed [c2d_pkg::OUT_W-1:0]    out_filtered_value,
  output logic                                out_status
);
  import c2d_pkg::*;

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int KER_DEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
  localparam int IAW       = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KAW       = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

  logic signed [DATA_W-1:0] img_mem_r [IMG_DEPTH];
  logic signed [DATA_W-1:0] ker_mem_r [KER_DEPTH];

  logic [IDX_W-1:0]         row_r, col_r;
  logic signed [DATA_W-1:0] img_q_r, ker_q_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [OUT_W-1:0]  acc_r;
  logic signed [OUT_W-1:0]  acc_shift;
  logic signed [OUT_W-1:0]  out_value_r;
  logic                     out_status_r;
  logic                     vld0_r, last0_r, vld1_r, last1_r, done_r;

  logic [KDIM_W-1:0]        pre_row, pre_col;
  logic signed [POS_W-1:0]  ir, ic;
  logic                     ir_ok, ic_ok, tap_ok;
  logic [IAW-1:0]           img_raddr, img_waddr;
  logic [KAW-1:0]           ker_raddr, ker_waddr;
  logic                     img_we, ker_we;
  logic [FRAC_W-1:0]        shift;

  assign sts.in_image = ({1'b0, in_row_index} < cfg.rows) &&
                        ({1'b0, in_col_index} < cfg.cols);
  assign sts.acc_done = done_r;

  // centre offset of the kernel, none for the empty kernel
  assign pre_row = cmd.bypass ? '0 : ((cfg.krows - 3'd1) >> 1);
  assign pre_col = cmd.bypass ? '0 : ((cfg.kcols - 3'd1) >> 1);

  assign ir = $signed({3'b000, row_r}) - $signed({6'd0, pre_row})
            + $signed({6'd0, cmd.tap_a});
  assign ic = $signed({3'b000, col_r}) - $signed({6'd0, pre_col})
            + $signed({6'd0, cmd.tap_b});
  assign ir_ok  = !ir[POS_W-1] && (ir < $signed({2'b00, cfg.rows}));
  assign ic_ok  = !ic[POS_W-1] && (ic < $signed({2'b00, cfg.cols}));
  assign tap_ok = cmd.tap_go && ir_ok && ic_ok;

  assign img_raddr = tap_ok ? IAW'(int'(ir[POS_W-2:0]) * MAX_COLS + int'(ic[POS_W-2:0]))
                            : '0;
  assign ker_raddr = tap_ok ? KAW'(int'(cmd.tap_a) * MAX_KERNEL_COLS + int'(cmd.tap_b))
                            : '0;

  assign img_we    = cmd.wr_image && (int'(in_row_index) < MAX_ROWS) &&
                     (int'(in_col_index) < MAX_COLS);
  assign ker_we    = cmd.wr_kernel && (int'(in_row_index) < MAX_KERNEL_ROWS) &&
                     (int'(in_col_index) < MAX_KERNEL_COLS);
  assign img_waddr = img_we ? IAW'(int'(in_row_index) * MAX_COLS + int'(in_col_index)) : '0;
  assign ker_waddr = ker_we ? KAW'(int'(in_row_index) * MAX_KERNEL_COLS +
                                   int'(in_col_index)) : '0;

  assign shift     = cmd.bypass ? '0 : cfg.frac;
  assign acc_shift = acc_r >>> shift;

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem_r[img_waddr] <= in_data_value;
    end
    img_q_r <= img_mem_r[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (ker_we) begin
      ker_mem_r[ker_waddr] <= in_data_value;
    end
    ker_q_r <= ker_mem_r[ker_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row_index;
      col_r <= in_col_index;
    end
    prod_r <= cmd.bypass ? PROD_W'(img_q_r) : img_q_r * ker_q_r;
    if (cmd.load_out) begin
      out_value_r  <= cmd.err ? '0 : acc_shift;
      out_status_r <= cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r  <= 1'b0;
      last0_r <= 1'b0;
      vld1_r  <= 1'b0;
      last1_r <= 1'b0;
      done_r  <= 1'b0;
      acc_r   <= '0;
    end else begin
      vld0_r  <= tap_ok;
      last0_r <= cmd.tap_go && cmd.tap_last;
      vld1_r  <= vld0_r;
      last1_r <= last0_r;
      done_r  <= last1_r;
      if (cmd.clear) begin
        acc_r <= '0;
      end else if (vld1_r) begin
        acc_r <= acc_r + OUT_W'(prod_r);
      end
    end
  end

  assign out_filtered_value = out_value_r;
  assign out_status         = out_status_r;

endmodule

[src/conv2d_same_zero_border_top.sv]
// same-size 2d correlation with zero border: operation and flow
// load items are written without leaving idle; a compute item walks its taps one per cycle,
// then drains through the read, product and accumulate registers and loads the result register;
// no new item is taken until the result is loaded; one mac unit
// out-of-image computes skip the taps, empty kernels pass the pixel; a held result stalls a compute
// synchronous active-low reset restores the registers to 64, 64, 3, 3, 0; stores keep data
`timescale 1ns / 1ps
module conv2d_same_zero_border_top #(
  parameter int MAX_ROWS        = 64,
  parameter int MAX_COLS        = 64,
  parameter int MAX_KERNEL_ROWS = 7,
  parameter int MAX_KERNEL_COLS = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [c2d_pkg::REQ_W-1:0]           in_req_type,
  input  logic [c2d_pkg::IDX_W-1:0]           in_row_index,
  input  logic [c2d_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [c2d_pkg::DATA_W-1:0]   in_data_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [c2d_pkg::OUT_W-1:0]    out_filtered_value,
  output logic                                out_status,
  input  logic                                cfg_we,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import c2d_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  c2d_cfg #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_COLS        (MAX_COLS),
    .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS (MAX_KERNEL_COLS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  c2d_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cfg         (cfg),
    .sts         (sts),
    .cmd         (cmd)
  );

  c2d_dp #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_COLS        (MAX_COLS),
    .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS (MAX_KERNEL_COLS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_row_index       (in_row_index),
    .in_col_index       (in_col_index),
    .in_data_value      (in_data_value),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .out_filtered_value (out_filtered_value),
    .out_status         (out_status)
  );

endmodule

[bench/tb_conv2d_same_zero_border_top.sv]
// self-checking bench for the same-size zero-border 2d correlation block
`timescale 1ns / 1ps
module tb_conv2d_same_zero_border_top;
  import c2d_pkg::*;

  localparam int IMG_DIM = 64;
  localparam int KRN_DIM = 7;
  localparam int ITEMS = 1450;
  localparam int SETTLE = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 4000000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic signed [DATA_W-1:0] data;
  } conv_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic status;
  } filt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [IDX_W-1:0] in_row_index = '0;
  logic [IDX_W-1:0] in_col_index = '0;
  logic signed [DATA_W-1:0] in_data_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_filtered_value;
  logic out_status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  conv2d_same_zero_border_top #(
    .MAX_ROWS(IMG_DIM),
    .MAX_COLS(IMG_DIM),
    .MAX_KERNEL_ROWS(KRN_DIM),
    .MAX_KERNEL_COLS(KRN_DIM)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_row_index(in_row_index),
    .in_col_index(in_col_index),
    .in_data_value(in_data_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_filtered_value(out_filtered_value),
    .out_status(out_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the block
  logic signed [DATA_W-1:0] img_mem [0:IMG_DIM*IMG_DIM-1];
  logic signed [DATA_W-1:0] krn_mem [0:KRN_DIM*KRN_DIM-1];
  logic [DIM_W-1:0] m_rows = 7'd64;
  logic [DIM_W-1:0] m_cols = 7'd64;
  logic [KDIM_W-1:0] m_krows = 3'd3;
  logic [KDIM_W-1:0] m_kcols = 3'd3;
  logic [FRAC_W-1:0] m_frac = 4'd0;

  // entries the stimulus has already queued a write for
  bit img_set [0:IMG_DIM*IMG_DIM-1];
  bit krn_set [0:KRN_DIM*KRN_DIM-1];

  conv_req_t req_backlog[$];
  filt_res_t pending_filt[$];
  conv_req_t cur_req;

  int queued_cnt = 0;
  int taken_cnt = 0;
  int eff_cnt = 0;
  int res_cnt = 0;
  int err_cnt = 0;
  int n_conv = 0;
  int n_bypass = 0;
  int n_outside = 0;
  int n_phases = 0;
  bit in_took = 1'b0;
  int in_wait = 0;
  bit in_calm = 1'b0;
  int out_wait = 0;
  bit out_calm = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 50) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic filt_res_t filter_at(int r, int c);
    filt_res_t res;
    int rows_c, cols_c, kr, kc, pre_r, pre_c, ir, ic;
    longint acc, px, cf;
    rows_c = (m_rows > IMG_DIM) ? IMG_DIM : m_rows;
    cols_c = (m_cols > IMG_DIM) ? IMG_DIM : m_cols;
    kr = (m_krows > KRN_DIM) ? KRN_DIM : m_krows;
    kc = (m_kcols > KRN_DIM) ? KRN_DIM : m_kcols;
    res.value = '0;
    res.status = STATUS_OUTSIDE;
    if (r < rows_c && c < cols_c) begin
      res.status = STATUS_OK;
      if (kr == 0 || kc == 0) begin
        px = img_mem[r*IMG_DIM+c];
        res.value = px[OUT_W-1:0];
      end else begin
        acc = 0;
        pre_r = (kr - 1) / 2;
        pre_c = (kc - 1) / 2;
        for (int a = 0; a < kr; a++) begin
          ir = r - pre_r + a;
          if (ir >= 0 && ir < rows_c) begin
            for (int b = 0; b < kc; b++) begin
              ic = c - pre_c + b;
              if (ic >= 0 && ic < cols_c) begin
                px = img_mem[ir*IMG_DIM+ic];
                cf = krn_mem[a*KRN_DIM+b];
                acc += px * cf;
              end
            end
          end
        end
        acc = acc >>> m_frac;
        res.value = acc[OUT_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic apply_item(input logic [REQ_W-1:0] rq, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic signed [DATA_W-1:0] v);
    filt_res_t res;
    case (rq)
      REQ_LOAD_KERNEL: if (r < KRN_DIM && c < KRN_DIM) krn_mem[r*KRN_DIM+c] = v;
      REQ_LOAD_IMAGE: img_mem[r*IMG_DIM+c] = v;
      REQ_COMPUTE: begin
        res = filter_at(r, c);
        pending_filt.push_back(res);
        if (res.status == STATUS_OUTSIDE) n_outside++;
        else if (m_krows == 0 || m_kcols == 0) n_bypass++;
        else n_conv++;
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic signed [OUT_W-1:0] got_v, input logic got_s);
    filt_res_t want;
    res_cnt++;
    if (pending_filt.size() == 0) begin
      report($sformatf("result with nothing expected: value %0d status %0b", got_v, got_s));
    end else begin
      want = pending_filt.pop_front();
      if (got_v !== want.value)
        report($sformatf("filtered_value %0d, expected %0d", got_v, want.value));
      if (got_s !== want.status)
        report($sformatf("status %0b, expected %0b", got_s, want.status));
    end
  endtask

  // outputs sampled at the rising edge
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) check_result(out_filtered_value, out_status);
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        taken_cnt++;
        apply_item(in_req_type, in_row_index, in_col_index, in_data_value);
      end
    end
  end

  function automatic int gap_len(bit calm);
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // item driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_wait > 0 || req_backlog.size() == 0) begin
        if (in_wait > 0) in_wait--;
        in_valid <= 1'b0;
      end else begin
        cur_req = req_backlog.pop_front();
        in_req_type <= cur_req.req;
        in_row_index <= cur_req.row;
        in_col_index <= cur_req.col;
        in_data_value <= cur_req.data;
        in_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        in_wait = gap_len(in_calm);
      end
    end
  end

  // result receiver, with one long hold-off while items are still queued
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && res_cnt >= 30 && req_backlog.size() > 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        out_wait = gap_len(out_calm);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return DATA_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic push_item(input logic [REQ_W-1:0] rq, input int r, input int c,
                           input logic [DATA_W-1:0] v);
    conv_req_t it;
    it.req = rq;
    it.row = r[IDX_W-1:0];
    it.col = c[IDX_W-1:0];
    it.data = v;
    req_backlog.push_back(it);
    queued_cnt++;
    case (rq)
      REQ_LOAD_KERNEL: if (r < KRN_DIM && c < KRN_DIM) begin
        krn_set[r*KRN_DIM+c] = 1'b1;
        eff_cnt++;
      end
      REQ_LOAD_IMAGE: begin
        img_set[r*IMG_DIM+c] = 1'b1;
        eff_cnt++;
      end
      REQ_COMPUTE: eff_cnt++;
      default: ;
    endcase
  endtask

  // load whatever a compute at (r, c) would read and has not been written yet
  task automatic feed_reads(input int r, input int c);
    int rows_c, cols_c, kr, kc, ir, ic;
    rows_c = (m_rows > IMG_DIM) ? IMG_DIM : m_rows;
    cols_c = (m_cols > IMG_DIM) ? IMG_DIM : m_cols;
    kr = m_krows;
    kc = m_kcols;
    if (r >= rows_c || c >= cols_c) return;
    if (kr == 0 || kc == 0) begin
      if (!img_set[r*IMG_DIM+c]) push_item(REQ_LOAD_IMAGE, r, c, rand_sample());
      return;
    end
    for (int a = 0; a < kr; a++) begin
      ir = r - (kr - 1) / 2 + a;
      if (ir >= 0 && ir < rows_c) begin
        for (int b = 0; b < kc; b++) begin
          ic = c - (kc - 1) / 2 + b;
          if (ic >= 0 && ic < cols_c) begin
            if (!img_set[ir*IMG_DIM+ic]) push_item(REQ_LOAD_IMAGE, ir, ic, rand_sample());
            if (!krn_set[a*KRN_DIM+b]) push_item(REQ_LOAD_KERNEL, a, b, rand_sample());
          end
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (!(taken_cnt == queued_cnt && pending_filt.size() == 0)) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_IMAGE_ROWS: m_rows = val;
      CFG_IMAGE_COLS: m_cols = val;
      CFG_KERNEL_ROWS: m_krows = val[KDIM_W-1:0];
      CFG_KERNEL_COLS: m_kcols = val[KDIM_W-1:0];
      CFG_FRAC_BITS: m_frac = val[FRAC_W-1:0];
      default: ;
    endcase
  endtask

  function automatic int dim_pick();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 12);
    if (p < 85) return $urandom_range(56, 64);
    return $urandom_range(0, 127);
  endfunction

  task automatic phase_cfg(input int ph, output int rr, output int cc, output int kr,
                           output int kc, output int fr);
    case (ph)
      0: begin rr = 8; cc = 8; kr = 7; kc = 7; fr = 15; end
      1: begin rr = 1; cc = 1; kr = 3; kc = 3; fr = 0; end
      2: begin rr = 64; cc = 64; kr = 5; kc = 3; fr = 4; end
      3: begin rr = 5; cc = 9; kr = 0; kc = 4; fr = 3; end
      4: begin rr = 6; cc = 3; kr = 5; kc = 0; fr = 0; end
      5: begin rr = 0; cc = 10; kr = 3; kc = 3; fr = 2; end
      6: begin rr = 127; cc = 100; kr = 7; kc = 2; fr = 8; end
      7: begin rr = 4; cc = 64; kr = 6; kc = 7; fr = 1; end
      8: begin rr = 12; cc = 0; kr = 2; kc = 2; fr = 1; end
      default: begin
        rr = dim_pick();
        cc = dim_pick();
        kr = $urandom_range(0, 7);
        kc = $urandom_range(0, 7);
        fr = $urandom_range(0, 15);
      end
    endcase
  endtask

  function automatic int pick_pos(int lim, int w0, int wsz);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, lim - 1);
    return $urandom_range(w0, w0 + wsz - 1);
  endfunction

  task automatic run_phase(input int ph);
    int rr, cc, kr, kc, fr;
    int rows_c, cols_c, wh, ww, r0, c0, start, budget, pick, r, c;
    bit drained;
    phase_cfg(ph, rr, cc, kr, kc, fr);
    wait_idle();
    write_reg(CFG_IMAGE_ROWS, DIM_W'(rr));
    write_reg(CFG_IMAGE_COLS, DIM_W'(cc));
    write_reg(CFG_KERNEL_ROWS, DIM_W'(kr));
    write_reg(CFG_KERNEL_COLS, DIM_W'(kc));
    write_reg(CFG_FRAC_BITS, DIM_W'(fr));
    @(negedge clk) cfg_we <= 1'b0;
    n_phases++;
    rows_c = (rr > IMG_DIM) ? IMG_DIM : rr;
    cols_c = (cc > IMG_DIM) ? IMG_DIM : cc;
    wh = (rows_c < 10) ? rows_c : 10;
    ww = (cols_c < 10) ? cols_c : 10;
    r0 = ($urandom_range(0, 2) == 0) ? 0 :
         ($urandom_range(0, 1) ? rows_c - wh : $urandom_range(0, rows_c - wh));
    c0 = ($urandom_range(0, 2) == 0) ? 0 :
         ($urandom_range(0, 1) ? cols_c - ww : $urandom_range(0, cols_c - ww));
    start = eff_cnt;
    budget = $urandom_range(60, 140);
    drained = 1'b0;
    while (eff_cnt - start < budget && queued_cnt < ITEMS) begin
      // sender pauses mid-phase until every result is back
      if (ph == 2 && !drained && eff_cnt - start >= budget / 2) begin
        drained = 1'b1;
        wait_idle();
      end
      pick = $urandom_range(0, 99);
      if (pick < 45 && rows_c > 0 && cols_c > 0) begin
        r = pick_pos(rows_c, r0, wh);
        c = pick_pos(cols_c, c0, ww);
        feed_reads(r, c);
        push_item(REQ_COMPUTE, r, c, rand_sample());
      end else if (pick < 70) begin
        if (rows_c > 0 && cols_c > 0 && $urandom_range(0, 3) != 0) begin
          r = pick_pos(rows_c, r0, wh);
          c = pick_pos(cols_c, c0, ww);
        end else begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end
        push_item(REQ_LOAD_IMAGE, r, c, rand_sample());
      end else if (pick < 80) begin
        push_item(REQ_LOAD_KERNEL, $urandom_range(0, KRN_DIM - 1),
                  $urandom_range(0, KRN_DIM - 1), rand_sample());
      end else begin
        case ($urandom_range(0, 2))
          0: push_item(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), rand_sample());
          1: begin
            if ($urandom_range(0, 1)) begin
              r = $urandom_range(KRN_DIM, 63);
              c = $urandom_range(0, 63);
            end else begin
              r = $urandom_range(0, 63);
              c = $urandom_range(KRN_DIM, 63);
            end
            push_item(REQ_LOAD_KERNEL, r, c, rand_sample());
          end
          default: begin
            if (rows_c < IMG_DIM && (cols_c == IMG_DIM || $urandom_range(0, 1))) begin
              r = $urandom_range(rows_c, 63);
              c = $urandom_range(0, 63);
            end else if (cols_c < IMG_DIM) begin
              r = $urandom_range(0, 63);
              c = $urandom_range(cols_c, 63);
            end else begin
              r = 63;
              c = 63;
            end
            feed_reads(r, c);
            push_item(REQ_COMPUTE, r, c, rand_sample());
          end
        endcase
      end
    end
  endtask

  initial begin
    int ph;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // corner pixels and extreme values under the reset settings
    push_item(REQ_LOAD_KERNEL, 0, 0, 16'h7FFF);
    push_item(REQ_LOAD_KERNEL, 0, 1, 16'h8000);
    push_item(REQ_LOAD_KERNEL, 0, 2, 16'hFFFF);
    push_item(REQ_LOAD_KERNEL, 1, 0, 16'h0001);
    push_item(REQ_LOAD_KERNEL, 1, 1, 16'h8000);
    push_item(REQ_LOAD_KERNEL, 1, 2, 16'h7FFF);
    push_item(REQ_LOAD_KERNEL, 2, 0, 16'h0000);
    push_item(REQ_LOAD_KERNEL, 2, 1, 16'h7FFF);
    push_item(REQ_LOAD_KERNEL, 2, 2, 16'h8000);
    push_item(REQ_LOAD_IMAGE, 0, 0, 16'h7FFF);
    push_item(REQ_LOAD_IMAGE, 0, 1, 16'h8000);
    push_item(REQ_LOAD_IMAGE, 1, 0, 16'h8000);
    push_item(REQ_LOAD_IMAGE, 1, 1, 16'h7FFF);
    push_item(REQ_LOAD_IMAGE, 62, 62, 16'hFFFF);
    push_item(REQ_LOAD_IMAGE, 62, 63, 16'h8000);
    push_item(REQ_LOAD_IMAGE, 63, 62, 16'h7FFF);
    push_item(REQ_LOAD_IMAGE, 63, 63, 16'h8000);
    push_item(REQ_COMPUTE, 0, 0, 16'hFFFF);
    push_item(REQ_COMPUTE, 63, 63, 16'h0000);
    push_item(REQ_LOAD_KERNEL, 63, 63, 16'h1234);
    push_item(REQ_LOAD_KERNEL, 7, 0, 16'hFFFF);
    push_item(REQ_UNUSED, 63, 63, 16'hFFFF);
    feed_reads(1, 1);
    push_item(REQ_COMPUTE, 1, 1, 16'h8000);

    for (ph = 0; queued_cnt < ITEMS; ph++) run_phase(ph);
    wait_idle();

    $display("covered %0d filter settings with %0d items and %0d results checked",
             n_phases, queued_cnt, res_cnt);
    $display("results: %0d windowed sums, %0d empty-kernel reads, %0d outside the image",
             n_conv, n_bypass, n_outside);
    if (err_cnt == 0) begin
      $display("tb_conv2d_same_zero_border_top: done, clean");
    end else begin
      $display("tb_conv2d_same_zero_border_top: done, errors");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout with %0d results still outstanding", pending_filt.size());
    $display("tb_conv2d_same_zero_border_top: done, errors");
    $finish;
  end

endmodule
